FILE: rtl/trmi_pkg.sv
// Shared types and constants for the tiny register machine interpreter.
// Holds opcodes, status and item kind codes, the result record and defaults.
// No dependencies.
package trmi_pkg;

  localparam int unsigned ProgramBytes  = 256;
  localparam int unsigned MessageBytes  = 32;
  localparam int unsigned RegisterCount = 16;
  localparam int unsigned RegIdxW       = 4;
  localparam int unsigned PcW           = 10;
  localparam int unsigned StepW         = 17;

  localparam logic [15:0] StepLimitReset = 16'd10000;
  localparam logic [7:0]  NewlineByte    = 8'h0A;

  localparam logic CfgStepLimit = 1'b0;

  typedef enum logic [1:0] {
    KIND_LOAD_PROG = 2'd0,
    KIND_LOAD_MSG  = 2'd1,
    KIND_START     = 2'd2,
    KIND_STEP      = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_RUN   = 3'd0,
    ST_HALT  = 3'd1,
    ST_PTR   = 3'd2,
    ST_LIMIT = 3'd3,
    ST_PC    = 3'd4
  } status_e;

  typedef enum logic [7:0] {
    OP_LDM  = 8'h01,
    OP_STM  = 8'h02,
    OP_MOVP = 8'h03,
    OP_LDI  = 8'h04,
    OP_XOR  = 8'h05,
    OP_ADD  = 8'h06,
    OP_DISP = 8'h07,
    OP_HALT = 8'h08,
    OP_JMP  = 8'h09,
    OP_JZ   = 8'h10
  } opcode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } res_t;

endpackage

FILE: rtl/trmi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the program store and the combined message and register store.
// No dependencies.
module trmi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/trmi_core.sv
// Instruction sequencer of the tiny register machine interpreter.
// Fetches through the program RAM, reads and writes back through the data RAM.
// Depends on trmi_pkg.
module trmi_core #(
  parameter int unsigned PROGRAM_BYTES = trmi_pkg::ProgramBytes,
  parameter int unsigned MESSAGE_BYTES = trmi_pkg::MessageBytes
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [15:0]              step_limit_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               kind_i,
  input  logic [7:0]               address_i,
  input  logic [7:0]               data_byte_i,
  input  logic [5:0]               message_length_i,
  output logic                     prog_we_o,
  output logic [$clog2(PROGRAM_BYTES)-1:0] prog_waddr_o,
  output logic [7:0]               prog_wdata_o,
  output logic [$clog2(PROGRAM_BYTES)-1:0] prog_raddr_o,
  input  logic [7:0]               prog_rdata_i,
  output logic                     data_we_o,
  output logic [$clog2(MESSAGE_BYTES+trmi_pkg::RegisterCount)-1:0] data_waddr_o,
  output logic [7:0]               data_wdata_o,
  output logic [$clog2(MESSAGE_BYTES+trmi_pkg::RegisterCount)-1:0] data_raddr_o,
  input  logic [7:0]               data_rdata_i,
  output logic                     res_valid_o,
  output trmi_pkg::res_t           res_o,
  input  logic                     res_ready_i,
  output trmi_pkg::status_e        status_o
);

  import trmi_pkg::*;

  localparam int unsigned PA = $clog2(PROGRAM_BYTES);
  localparam int unsigned DA = $clog2(MESSAGE_BYTES + RegisterCount);
  localparam int unsigned PW = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
  localparam int unsigned LW = $clog2(MESSAGE_BYTES + 1);
  localparam logic [DA-1:0] RegBase = DA'(MESSAGE_BYTES);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_F1    = 10'b00_0000_0010,
    S_F2    = 10'b00_0000_0100,
    S_F3    = 10'b00_0000_1000,
    S_DEC   = 10'b00_0001_0000,
    S_M1    = 10'b00_0010_0000,
    S_M2    = 10'b00_0100_0000,
    S_DREAD = 10'b00_1000_0000,
    S_DISP  = 10'b01_0000_0000,
    S_PUSH  = 10'b10_0000_0000
  } state_e;

  function automatic logic [DA-1:0] reg_addr(input logic [RegIdxW-1:0] r);
    return RegBase + DA'(r);
  endfunction

  state_e                state_q, state_d;
  logic [PcW-1:0]        pc_q, pc_d;
  logic [PW-1:0]         ptr_q, ptr_d;
  logic                  zf_q, zf_d;
  logic [StepW-1:0]      steps_q, steps_d;
  logic [LW-1:0]         len_q, len_d;
  status_e               status_q, status_d;
  logic [RegisterCount-1:0] vld_q, vld_d;
  logic                  prog_oob_q, prog_oob_d;
  logic [7:0]            op_q, op_d;
  logic [7:0]            a1_q, a1_d;
  logic [7:0]            a2_q, a2_d;
  logic [7:0]            opnd_q, opnd_d;
  res_t                  res_q, res_d;
  logic [LW-1:0]         n_q, n_d;

  logic                  accept;
  logic [1:0]            fidx;
  logic [PcW-1:0]        fetch_full;
  logic [7:0]            fetched;
  logic [StepW-1:0]      step_next;
  logic [PcW-1:0]        a1_sext;
  logic [PcW-1:0]        np;
  logic                  np_bad;
  logic [PcW-1:0]        pc_step;
  logic [PcW-1:0]        pc_jump;
  logic [RegIdxW-1:0]    r1;
  logic [RegIdxW-1:0]    r2;
  logic [7:0]            alu_b;
  logic [7:0]            alu_r;
  res_t                  res_single;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    case (state_q)
      S_F1:    fidx = 2'd1;
      S_F2:    fidx = 2'd2;
      default: fidx = 2'd0;
    endcase
  end

  assign fetch_full   = pc_q + PcW'(fidx);
  assign prog_raddr_o = fetch_full[PA-1:0];
  assign prog_oob_d   = (fetch_full >= PcW'(PROGRAM_BYTES));
  assign fetched      = prog_oob_q ? 8'd0 : prog_rdata_i;

  assign step_next = steps_q + StepW'(1);
  assign a1_sext   = {{(PcW-8){a1_q[7]}}, a1_q};
  assign np        = PcW'(ptr_q) + a1_sext;
  assign np_bad    = np[PcW-1] || (np >= PcW'(len_q));
  assign pc_step   = pc_q + PcW'(3);
  assign pc_jump   = pc_q + a1_sext + PcW'(3);
  assign r1        = a1_q[RegIdxW-1:0];
  assign r2        = a2_q[RegIdxW-1:0];
  assign alu_b     = vld_q[r1] ? data_rdata_i : 8'd0;
  assign alu_r     = (op_q == OP_XOR) ? (alu_b ^ opnd_q) : (alu_b + opnd_q);

  assign res_single = '{data: 8'd0, valid: 1'b0, last: 1'b1};

  always_comb begin
    state_d      = state_q;
    pc_d         = pc_q;
    ptr_d        = ptr_q;
    zf_d         = zf_q;
    steps_d      = steps_q;
    len_d        = len_q;
    status_d     = status_q;
    vld_d        = vld_q;
    op_d         = op_q;
    a1_d         = a1_q;
    a2_d         = a2_q;
    opnd_d       = opnd_q;
    res_d        = res_q;
    n_d          = n_q;
    prog_we_o    = 1'b0;
    prog_waddr_o = PA'(address_i);
    prog_wdata_o = data_byte_i;
    data_we_o    = 1'b0;
    data_waddr_o = DA'(address_i);
    data_wdata_o = data_byte_i;
    data_raddr_o = DA'(ptr_q);
    res_valid_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (kind_i)
            KIND_LOAD_PROG: begin
              prog_we_o = (9'(address_i) < 9'(PROGRAM_BYTES));
            end
            KIND_LOAD_MSG: begin
              data_we_o = (9'(address_i) < 9'(MESSAGE_BYTES));
            end
            KIND_START: begin
              vld_d    = '0;
              pc_d     = '0;
              ptr_d    = '0;
              zf_d     = 1'b0;
              steps_d  = '0;
              status_d = ST_RUN;
              if (7'(message_length_i) > 7'(MESSAGE_BYTES)) begin
                len_d = LW'(MESSAGE_BYTES);
              end else begin
                len_d = LW'(message_length_i);
              end
            end
            KIND_STEP: begin
              res_d = res_single;
              if (status_q != ST_RUN) begin
                state_d = S_PUSH;
              end else if (pc_q >= PcW'(PROGRAM_BYTES)) begin
                status_d = ST_PC;
                state_d  = S_PUSH;
              end else begin
                steps_d = step_next;
                if (step_next > StepW'(step_limit_i)) begin
                  status_d = ST_LIMIT;
                  state_d  = S_PUSH;
                end else begin
                  state_d = S_F1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_F1: begin
        op_d    = fetched;
        state_d = S_F2;
      end
      S_F2: begin
        a1_d    = fetched;
        state_d = S_F3;
      end
      S_F3: begin
        a2_d    = fetched;
        state_d = S_DEC;
      end
      S_DEC: begin
        res_d   = res_single;
        state_d = S_PUSH;
        pc_d    = pc_step;
        case (op_q)
          OP_LDM: begin
            data_raddr_o = DA'(ptr_q);
            state_d      = S_M1;
          end
          OP_STM: begin
            data_raddr_o = reg_addr(r1);
            state_d      = S_M1;
          end
          OP_MOVP: begin
            if (np_bad) begin
              status_d = ST_PTR;
              pc_d     = pc_q;
            end else begin
              ptr_d = np[PW-1:0];
            end
          end
          OP_LDI: begin
            data_we_o    = 1'b1;
            data_waddr_o = reg_addr(r2);
            data_wdata_o = a1_q;
            vld_d[r2]    = 1'b1;
          end
          OP_XOR, OP_ADD: begin
            data_raddr_o = reg_addr(r2);
            state_d      = S_M1;
          end
          OP_DISP: begin
            n_d     = '0;
            state_d = S_DREAD;
          end
          OP_HALT: begin
            status_d = ST_HALT;
            pc_d     = pc_q;
          end
          OP_JMP: begin
            pc_d = pc_jump;
          end
          OP_JZ: begin
            pc_d = zf_q ? pc_jump : pc_step;
          end
          default: ;
        endcase
      end
      S_M1: begin
        state_d = S_PUSH;
        case (op_q)
          OP_LDM: begin
            data_we_o    = 1'b1;
            data_waddr_o = reg_addr(r1);
            data_wdata_o = data_rdata_i;
            vld_d[r1]    = 1'b1;
          end
          OP_STM: begin
            data_we_o    = 1'b1;
            data_waddr_o = DA'(ptr_q);
            data_wdata_o = vld_q[r1] ? data_rdata_i : 8'd0;
          end
          default: begin
            opnd_d       = vld_q[r2] ? data_rdata_i : 8'd0;
            data_raddr_o = reg_addr(r1);
            state_d      = S_M2;
          end
        endcase
      end
      S_M2: begin
        data_we_o    = 1'b1;
        data_waddr_o = reg_addr(r1);
        data_wdata_o = alu_r;
        vld_d[r1]    = 1'b1;
        zf_d         = (alu_r == 8'd0);
        state_d      = S_PUSH;
      end
      S_DREAD: begin
        if (n_q == LW'(MESSAGE_BYTES)) begin
          res_d   = '{data: NewlineByte, valid: 1'b1, last: 1'b1};
          state_d = S_PUSH;
        end else begin
          data_raddr_o = DA'(n_q);
          state_d      = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_PUSH;
        if (data_rdata_i != 8'd0) begin
          res_d = '{data: data_rdata_i, valid: 1'b1, last: 1'b0};
          n_d   = n_q + LW'(1);
        end else begin
          res_d = '{data: NewlineByte, valid: 1'b1, last: 1'b1};
        end
      end
      S_PUSH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = res_q.last ? S_IDLE : S_DREAD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pc_q       <= '0;
      ptr_q      <= '0;
      zf_q       <= 1'b0;
      steps_q    <= '0;
      len_q      <= '0;
      status_q   <= ST_RUN;
      vld_q      <= '0;
      prog_oob_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pc_q       <= pc_d;
      ptr_q      <= ptr_d;
      zf_q       <= zf_d;
      steps_q    <= steps_d;
      len_q      <= len_d;
      status_q   <= status_d;
      vld_q      <= vld_d;
      prog_oob_q <= prog_oob_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    a1_q   <= a1_d;
    a2_q   <= a2_d;
    opnd_q <= opnd_d;
    res_q  <= res_d;
    n_q    <= n_d;
  end

  assign res_o    = res_q;
  assign status_o = status_q;

endmodule

FILE: rtl/tiny_register_machine_interpreter.sv
// Tiny register machine interpreter: load and start items are taken one per cycle while idle.
// A step result passes fetch states F1, F2, F3 and decode, then M1 for load or store through
// the pointer, M1 and M2 for XOR and ADD, into the push state; a stopped machine goes straight
// to push. The single read ports of the program RAM (three byte fetches) and data RAM set this.
// Display loops S_DREAD, S_DISP, S_PUSH per byte; the next item is taken back in idle.
// Reset (async, active low) clears run state and register valid bits; step_limit is 10000.
module tiny_register_machine_interpreter #(
  parameter int unsigned PROGRAM_BYTES = trmi_pkg::ProgramBytes,
  parameter int unsigned MESSAGE_BYTES = trmi_pkg::MessageBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  address_i,
  input  logic [7:0]  data_byte_i,
  input  logic [5:0]  message_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  display_byte_o,
  output logic        byte_valid_o,
  output logic        last_o,
  output logic [2:0]  status_code_o
);

  import trmi_pkg::*;

  localparam int unsigned PA = $clog2(PROGRAM_BYTES);
  localparam int unsigned DD = MESSAGE_BYTES + RegisterCount;
  localparam int unsigned DA = $clog2(DD);

  logic [15:0]   step_limit_q;
  logic          cfg_write;

  logic          prog_we;
  logic [PA-1:0] prog_waddr;
  logic [7:0]    prog_wdata;
  logic [PA-1:0] prog_raddr;
  logic [7:0]    prog_rdata;
  logic          data_we;
  logic [DA-1:0] data_waddr;
  logic [7:0]    data_wdata;
  logic [DA-1:0] data_raddr;
  logic [7:0]    data_rdata;

  logic          res_valid;
  logic          res_ready;
  res_t          res;
  status_e       status;

  logic          out_valid_q;
  res_t          out_res_q;
  logic [2:0]    out_status_q;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == CfgStepLimit) ? {16'd0, step_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_limit_q <= StepLimitReset;
    end else if (cfg_write && (paddr[2] == CfgStepLimit)) begin
      step_limit_q <= pwdata[15:0];
    end
  end

  trmi_ram #(
    .WIDTH(8),
    .DEPTH(PROGRAM_BYTES)
  ) u_prog_ram (
    .clk_i  (clk_i),
    .we_i   (prog_we),
    .waddr_i(prog_waddr),
    .wdata_i(prog_wdata),
    .raddr_i(prog_raddr),
    .rdata_o(prog_rdata)
  );

  trmi_ram #(
    .WIDTH(8),
    .DEPTH(DD)
  ) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (data_we),
    .waddr_i(data_waddr),
    .wdata_i(data_wdata),
    .raddr_i(data_raddr),
    .rdata_o(data_rdata)
  );

  trmi_core #(
    .PROGRAM_BYTES(PROGRAM_BYTES),
    .MESSAGE_BYTES(MESSAGE_BYTES)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_limit_i    (step_limit_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .address_i       (address_i),
    .data_byte_i     (data_byte_i),
    .message_length_i(message_length_i),
    .prog_we_o       (prog_we),
    .prog_waddr_o    (prog_waddr),
    .prog_wdata_o    (prog_wdata),
    .prog_raddr_o    (prog_raddr),
    .prog_rdata_i    (prog_rdata),
    .data_we_o       (data_we),
    .data_waddr_o    (data_waddr),
    .data_wdata_o    (data_wdata),
    .data_raddr_o    (data_raddr),
    .data_rdata_i    (data_rdata),
    .res_valid_o     (res_valid),
    .res_o           (res),
    .res_ready_i     (res_ready),
    .status_o        (status)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q    <= res;
      out_status_q <= 3'(status);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign display_byte_o = out_res_q.data;
  assign byte_valid_o   = out_res_q.valid;
  assign last_o         = out_res_q.last;
  assign status_code_o  = out_status_q;

endmodule
